### rtl/gba_pkg.sv
// shared constants and codes for the grouped bitmap allocator
package gba_pkg;

    localparam int MAX_GROUPS     = 16;
    localparam int BITS_PER_GROUP = 8192;
    localparam int WORD_W         = 32;
    localparam int BIT_W          = $clog2(WORD_W);
    localparam int GRP_W          = $clog2(MAX_GROUPS);
    localparam int WIDX_W         = $clog2(BITS_PER_GROUP / WORD_W);
    localparam int ADDR_W         = GRP_W + WIDX_W;
    localparam int STORE_WORDS    = MAX_GROUPS * BITS_PER_GROUP / WORD_W;
    localparam int BPG_W          = 14;
    localparam int GCNT_W         = 5;
    localparam int NUM_W          = 18;
    localparam int CFG_W          = 18;
    localparam int CFG_IDX_W      = 3;

    localparam int GROUP_BITS_W   = 14;

    localparam logic [GROUP_BITS_W-1:0] GROUP_MAX = '1;
    localparam logic [NUM_W-1:0]        TOTAL_MAX = '1;

    // command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_MARK  = 2'd2;
    localparam logic [1:0] CMD_INIT  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BPG   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INODE_BPG   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_INODE = 3'd4;

    typedef logic [GROUP_BITS_W-1:0] t_gcount;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } t_scan;

endpackage

### rtl/gba_bitmap_ram.sv
// single-port-write, registered-read bitmap word memory
module gba_bitmap_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/gba_scan.sv
// first-clear-bit finder over one bitmap word, bits past the group end count as set
module gba_scan (
    input  logic [gba_pkg::WORD_W-1:0] i_word,
    input  logic                       i_last,
    input  logic [gba_pkg::BIT_W-1:0]  i_lim,
    output gba_pkg::t_scan             o_scan
);
    import gba_pkg::*;

    logic [WORD_W-1:0] masked;

    // force bits beyond the group end to set in the last word
    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            masked[i] = i_word[i] | (i_last && (i > int'(i_lim)));
        end
    end

    // lowest clear bit
    always_comb begin
        o_scan.found = 1'b0;
        o_scan.idx   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!masked[i]) begin
                o_scan.found = 1'b1;
                o_scan.idx   = BIT_W'(i);
            end
        end
    end

endmodule

### rtl/grouped_bitmap_allocator_top.sv
// grouped block/inode bitmap allocator with a word-scan sequencer
//
//  channel      dir  contents
//  s_axis_*     in   tdata {number, cmd}, tuser kind
//  m_axis_*     out  tdata {alloc_number, status}
//  i_cfg_*      in   register index and write data
//
//  after reset a clearing pass over every word zeroes both bitmaps; no item
//  is taken until it ends. init makes one pass over its store, clearing that bitmap.
//  alloc skips groups with no free bits and scans each other group word by
//  word; free and mark used find the group by repeated subtract steps.
//  one item at a time; a finished result waits in the output register.
module grouped_bitmap_allocator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,  // cmd[1:0], number[19:2]
    input  logic                          s_axis_tuser,  // kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,  // status[1:0], alloc_number[19:2]
    input  logic                          i_cfg_we,
    input  logic [gba_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [gba_pkg::CFG_W-1:0]     i_cfg_data
);
    import gba_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_GRP  = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_LOC  = 4'd5;
    localparam logic [3:0] S_LRD  = 4'd6;
    localparam logic [3:0] S_LWR  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]        r_state;
    logic [BPG_W-1:0]  r_bbpg, r_ibpg;
    logic [GCNT_W-1:0] r_gcnt;
    logic [16:0]       r_fdb;
    logic [NUM_W-1:0]  r_fui;

    logic [1:0]        r_cmd;
    logic              r_kind;
    logic [NUM_W-1:0]  r_rem;
    logic [GCNT_W-1:0] r_g;
    logic [NUM_W-1:0]  r_gbase;
    logic [WIDX_W-1:0] r_w;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clr_b, r_clr_i;
    logic [1:0]        r_status;
    logic [NUM_W-1:0]  r_result;
    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [NUM_W-1:0]  r_out_num;

    t_gcount           r_bgf [MAX_GROUPS];
    t_gcount           r_igf [MAX_GROUPS];
    logic [NUM_W-1:0]  r_btot, r_itot;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bbpg <= BPG_W'(8192);
            r_ibpg <= BPG_W'(2048);
            r_gcnt <= GCNT_W'(16);
            r_fdb  <= 17'd1;
            r_fui  <= NUM_W'(11);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_BLOCK_BPG:   r_bbpg <= i_cfg_data[BPG_W-1:0];
                REG_INODE_BPG:   r_ibpg <= i_cfg_data[BPG_W-1:0];
                REG_GROUP_COUNT: r_gcnt <= i_cfg_data[GCNT_W-1:0];
                REG_FIRST_DATA:  r_fdb  <= i_cfg_data[16:0];
                REG_FIRST_INODE: r_fui  <= i_cfg_data[NUM_W-1:0];
                default: ;
            endcase
        end
    end

    // effective configuration for the item's kind
    logic [BPG_W-1:0]  cfg_bpg, bpg, bpg_m1;
    logic [GCNT_W-1:0] ng;
    logic [NUM_W-1:0]  limit;
    logic              in_kind;
    logic [BPG_W-1:0]  in_bpg;

    always_comb begin
        in_kind = s_axis_tuser;
        in_bpg  = in_kind ? r_ibpg : r_bbpg;
        if (in_bpg > BPG_W'(BITS_PER_GROUP)) in_bpg = BPG_W'(BITS_PER_GROUP);
        cfg_bpg = r_kind ? r_ibpg : r_bbpg;
        bpg     = (cfg_bpg > BPG_W'(BITS_PER_GROUP)) ? BPG_W'(BITS_PER_GROUP) : cfg_bpg;
        bpg_m1  = bpg - BPG_W'(1);
        ng      = (r_gcnt > GCNT_W'(MAX_GROUPS)) ? GCNT_W'(MAX_GROUPS) : r_gcnt;
        limit   = r_kind ? r_fui : {1'b0, r_fdb};
    end

    // bitmap memories
    logic              we_b, we_i, wr_en;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [WORD_W-1:0] wdata, rdata_b, rdata_i, rdata;
    t_scan             scan;
    logic [GRP_W-1:0]  gi;

    assign gi    = r_g[GRP_W-1:0];
    assign rdata = r_kind ? rdata_i : rdata_b;
    assign we_b  = (r_state == S_CLR) ? r_clr_b : (wr_en && !r_kind);
    assign we_i  = (r_state == S_CLR) ? r_clr_i : (wr_en && r_kind);

    gba_bitmap_ram #(.DEPTH(STORE_WORDS), .WIDTH(WORD_W)) u_bram (
        .i_clk(i_clk), .i_we(we_b), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata_b)
    );

    gba_bitmap_ram #(.DEPTH(STORE_WORDS), .WIDTH(WORD_W)) u_iram (
        .i_clk(i_clk), .i_we(we_i), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata_i)
    );

    gba_scan u_scan (
        .i_word(rdata),
        .i_last(r_w == bpg_m1[BPG_W-2:BIT_W]),
        .i_lim (bpg_m1[BIT_W-1:0]),
        .o_scan(scan)
    );

    // memory address and data selection
    logic [NUM_W-1:0] num;
    assign num = r_gbase + NUM_W'({r_w, scan.idx}) + NUM_W'(r_kind);

    always_comb begin
        wr_en = 1'b0;
        waddr = r_clr_addr;
        wdata = '0;
        raddr = {gi, r_w};
        if (r_state == S_LRD || r_state == S_LWR) begin
            raddr = {gi, r_rem[WIDX_W+BIT_W-1:BIT_W]};
        end
        if (r_state == S_CHK) begin
            wr_en = scan.found;
            waddr = {gi, r_w};
            wdata = rdata | (WORD_W'(1) << scan.idx);
        end else if (r_state == S_LWR) begin
            wr_en = 1'b1;
            waddr = {gi, r_rem[WIDX_W+BIT_W-1:BIT_W]};
            if (r_cmd == CMD_MARK) wdata = rdata | (WORD_W'(1) << r_rem[BIT_W-1:0]);
            else wdata = rdata & ~(WORD_W'(1) << r_rem[BIT_W-1:0]);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);

    logic              acc;
    logic              out_load;
    logic [1:0]        in_cmd;
    logic [NUM_W-1:0]  in_num, in_n;
    logic [GCNT_W-1:0] g_next;
    t_gcount           gf_cur;
    logic [NUM_W-1:0]  tot_cur;

    assign acc      = s_axis_tvalid && s_axis_tready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
    assign in_cmd   = s_axis_tdata[1:0];
    assign in_num   = s_axis_tdata[NUM_W+1:2];
    assign in_n     = in_kind ? in_num - NUM_W'(1) : in_num;
    assign g_next   = r_g + GCNT_W'(1);
    assign gf_cur   = r_kind ? r_igf[gi] : r_bgf[gi];
    assign tot_cur  = r_kind ? r_itot : r_btot;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_clr_b     <= 1'b1;
            r_clr_i     <= 1'b1;
            r_out_valid <= 1'b0;
            r_btot      <= '0;
            r_itot      <= '0;
            for (int i = 0; i < MAX_GROUPS; i++) begin
                r_bgf[i] <= '0;
                r_igf[i] <= '0;
            end
        end else begin
            // output register: load a finished result, drop it once taken
            if (out_load) r_out_valid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(STORE_WORDS - 1)) begin
                        r_clr_b <= 1'b0;
                        r_clr_i <= 1'b0;
                        r_state <= (r_clr_b && r_clr_i) ? S_IDLE : S_DONE;
                    end
                end
                S_IDLE: begin
                    if (acc) begin
                        r_cmd    <= in_cmd;
                        r_kind   <= in_kind;
                        r_rem    <= in_n;
                        r_g      <= '0;
                        r_gbase  <= '0;
                        r_w      <= '0;
                        r_result <= '0;
                        r_status <= ST_OK;
                        unique case (in_cmd)
                            CMD_ALLOC: begin
                                if ((in_kind ? r_itot : r_btot) == '0 || in_bpg == '0) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_GRP;
                                end
                            end
                            CMD_FREE, CMD_MARK: begin
                                if (in_bpg == '0 || ng == '0 ||
                                    (in_kind && in_num == '0)) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_LOC;
                                end
                            end
                            CMD_INIT: begin
                                for (int i = 0; i < MAX_GROUPS; i++) begin
                                    if (in_kind) r_igf[i] <= (i < int'(ng)) ? in_bpg : '0;
                                    else r_bgf[i] <= (i < int'(ng)) ? in_bpg : '0;
                                end
                                if (in_kind) r_itot <= NUM_W'(ng) * NUM_W'(in_bpg);
                                else r_btot <= NUM_W'(ng) * NUM_W'(in_bpg);
                                r_clr_b    <= !in_kind;
                                r_clr_i    <= in_kind;
                                r_clr_addr <= '0;
                                r_state    <= S_CLR;
                            end
                            default: ;
                        endcase
                    end
                end
                S_GRP: begin
                    if (r_g >= ng) begin
                        r_status <= ST_FULL;
                        r_state  <= S_DONE;
                    end else if (gf_cur == '0) begin
                        r_g     <= g_next;
                        r_gbase <= r_gbase + NUM_W'(bpg);
                    end else begin
                        r_w     <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (scan.found && num >= limit) begin
                        if (r_kind) begin
                            r_igf[gi] <= r_igf[gi] - t_gcount'(1);
                            r_itot    <= r_itot - NUM_W'(1);
                        end else begin
                            r_bgf[gi] <= r_bgf[gi] - t_gcount'(1);
                            r_btot    <= r_btot - NUM_W'(1);
                        end
                        r_result <= num;
                        r_state  <= S_DONE;
                    end else if (scan.found || r_w == bpg_m1[BPG_W-2:BIT_W]) begin
                        // low number or group exhausted: next group
                        r_g     <= g_next;
                        r_gbase <= r_gbase + NUM_W'(bpg);
                        r_state <= S_GRP;
                    end else begin
                        r_w     <= r_w + WIDX_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_LOC: begin
                    // number divided by bits per group, one subtract a step
                    if (r_rem < NUM_W'(bpg)) begin
                        r_state <= S_LRD;
                    end else if (g_next >= ng) begin
                        r_status <= ST_RANGE;
                        r_state  <= S_DONE;
                    end else begin
                        r_rem <= r_rem - NUM_W'(bpg);
                        r_g   <= g_next;
                    end
                end
                S_LRD: r_state <= S_LWR;
                S_LWR: begin
                    if (r_cmd == CMD_FREE) begin
                        if (r_kind) begin
                            if (gf_cur != GROUP_MAX) r_igf[gi] <= gf_cur + t_gcount'(1);
                            if (tot_cur != TOTAL_MAX) r_itot <= tot_cur + NUM_W'(1);
                        end else begin
                            if (gf_cur != GROUP_MAX) r_bgf[gi] <= gf_cur + t_gcount'(1);
                            if (tot_cur != TOTAL_MAX) r_btot <= tot_cur + NUM_W'(1);
                        end
                    end else begin
                        if (r_kind) begin
                            if (gf_cur != '0) r_igf[gi] <= gf_cur - t_gcount'(1);
                            if (tot_cur != '0) r_itot <= tot_cur - NUM_W'(1);
                        end else begin
                            if (gf_cur != '0) r_bgf[gi] <= gf_cur - t_gcount'(1);
                            if (tot_cur != '0) r_btot <= tot_cur - NUM_W'(1);
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_status <= r_status;
                        r_out_num    <= (r_status == ST_OK && r_cmd == CMD_ALLOC) ?
                                        r_result : '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_num, r_out_status};

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while busy");
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[19:2] == '0)
        else $error("nonzero number on failed result");
    a_group_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD || r_state == S_LRD |-> r_g < ng)
        else $error("word read outside groups in use");
`endif

endmodule
